[sv/mhpq_pkg.sv]
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 8;
    localparam int STATUS_W     = 2;

    typedef enum logic [0:0] {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } res_t;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2
    } sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_EX_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins_start;
        logic ex_start;
        logic refuse_full;
        logic refuse_empty;
        logic up_read;
        logic up_step;
        logic up_place;
        logic ex_load;
        logic dn_read;
        logic dn_step;
        logic dn_place;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_root;
        logic up_swap;
        logic has_left;
        sel_t dn_sel;
        logic out_busy;
    } stat_t;

endpackage

[sv/mhpq_ctrl.sv]
// Sequencer for insert sift-up and extract sift-down.
module mhpq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mhpq_pkg::func_t   in_func,
    output logic              in_ready,
    input  mhpq_pkg::stat_t   stat,
    output mhpq_pkg::cmd_t    cmd
);

    mhpq_pkg::state_t state_reg;
    mhpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == mhpq_pkg::FUNC_INSERT)
                    begin
                        state_next = stat.full ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_RD;
                    end
                    else
                    begin
                        state_next = stat.empty ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_EX_LOAD;
                    end
                end
            end
            mhpq_pkg::ST_UP_RD:
            begin
                state_next = stat.pos_root ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_CMP;
            end
            mhpq_pkg::ST_UP_CMP:
            begin
                state_next = stat.up_swap ? mhpq_pkg::ST_UP_RD : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_EX_LOAD:
            begin
                state_next = stat.last_one ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_RD;
            end
            mhpq_pkg::ST_DN_RD:
            begin
                state_next = stat.has_left ? mhpq_pkg::ST_DN_CMP : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DN_CMP:
            begin
                state_next = (stat.dn_sel == mhpq_pkg::SEL_NONE) ? mhpq_pkg::ST_DONE
                                                                 : mhpq_pkg::ST_DN_RD;
            end
            mhpq_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == mhpq_pkg::FUNC_INSERT)
                    begin
                        cmd.refuse_full = stat.full;
                        cmd.ins_start   = !stat.full;
                    end
                    else
                    begin
                        cmd.refuse_empty = stat.empty;
                        cmd.ex_start     = !stat.empty;
                    end
                end
            end
            mhpq_pkg::ST_UP_RD:
            begin
                cmd.up_place = stat.pos_root;
                cmd.up_read  = !stat.pos_root;
            end
            mhpq_pkg::ST_UP_CMP:
            begin
                cmd.up_step  = stat.up_swap;
                cmd.up_place = !stat.up_swap;
            end
            mhpq_pkg::ST_EX_LOAD:
            begin
                cmd.ex_load = 1'b1;
            end
            mhpq_pkg::ST_DN_RD:
            begin
                cmd.dn_read  = stat.has_left;
                cmd.dn_place = !stat.has_left;
            end
            mhpq_pkg::ST_DN_CMP:
            begin
                cmd.dn_place = (stat.dn_sel == mhpq_pkg::SEL_NONE);
                cmd.dn_step  = (stat.dn_sel != mhpq_pkg::SEL_NONE);
            end
            mhpq_pkg::ST_DONE:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/mhpq_dpath.sv]
// Heap store, sift registers, comparators and result register.
module mhpq_dpath
#(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mhpq_pkg::cmd_t                        cmd,
    output mhpq_pkg::stat_t                       stat,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     in_key,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]     out_value,
    output mhpq_pkg::res_t                        out_res,
    output logic        [mhpq_pkg::COUNT_W-1:0]   out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int KW = mhpq_pkg::KEY_W;
    localparam int OW = mhpq_pkg::COUNT_W;

    logic signed [KW-1:0] mem [CAPACITY];

    logic        [CW-1:0] count_reg, count_next;
    logic        [AW-1:0] pos_reg, pos_next;
    logic signed [KW-1:0] cur_reg, cur_next;
    logic signed [KW-1:0] val_reg, val_next;
    mhpq_pkg::res_t       res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [KW-1:0] m_value_reg, m_value_next;
    mhpq_pkg::res_t       m_res_reg, m_res_next;
    logic        [OW-1:0] m_count_reg, m_count_next;
    logic signed [KW-1:0] rd_a_reg, rd_b_reg;

    logic                 we;
    logic        [AW-1:0] waddr;
    logic signed [KW-1:0] wdata;
    logic                 rd_a_en, rd_b_en;
    logic        [AW-1:0] raddr_a, raddr_b;

    logic        [IW-1:0] lc, rc, size_ext;
    logic        [AW-1:0] parent;
    logic        [CW-1:0] last_idx;
    logic                 has_left, has_right, l_win, r_win;
    logic signed [KW-1:0] best_val;
    mhpq_pkg::sel_t       dn_sel;
    logic [CW+OW-1:0]     count_wide;

    assign lc         = (IW'(pos_reg) << 1) + IW'(1);
    assign rc         = lc + IW'(1);
    assign size_ext   = IW'(count_reg);
    assign has_left   = lc < size_ext;
    assign has_right  = rc < size_ext;
    assign parent     = (pos_reg - AW'(1)) >> 1;
    assign last_idx   = count_reg - CW'(1);
    assign count_wide = {{OW{1'b0}}, count_reg};

    // Pick among parent, left child and right child; ties keep the earlier one.
    always_comb
    begin
        l_win    = cur_reg < rd_a_reg;
        best_val = l_win ? rd_a_reg : cur_reg;
        r_win    = has_right && (best_val < rd_b_reg);
        if (r_win)
        begin
            dn_sel = mhpq_pkg::SEL_RIGHT;
        end
        else if (l_win)
        begin
            dn_sel = mhpq_pkg::SEL_LEFT;
        end
        else
        begin
            dn_sel = mhpq_pkg::SEL_NONE;
        end
    end

    always_comb
    begin
        stat.full     = count_reg == CW'(CAPACITY);
        stat.empty    = count_reg == '0;
        stat.last_one = count_reg == CW'(1);
        stat.pos_root = pos_reg == '0;
        stat.up_swap  = cur_reg > rd_a_reg;
        stat.has_left = has_left;
        stat.dn_sel   = dn_sel;
        stat.out_busy = m_valid_reg && !out_ready;
    end

    // Store ports
    always_comb
    begin
        we      = 1'b0;
        waddr   = pos_reg;
        wdata   = cur_reg;
        rd_a_en = 1'b0;
        rd_b_en = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        if (cmd.up_place || cmd.dn_place)
        begin
            we = 1'b1;
        end
        if (cmd.up_step)
        begin
            we    = 1'b1;
            wdata = rd_a_reg;
        end
        if (cmd.dn_step)
        begin
            we    = 1'b1;
            wdata = (dn_sel == mhpq_pkg::SEL_RIGHT) ? rd_b_reg : rd_a_reg;
        end
        if (cmd.up_read)
        begin
            rd_a_en = 1'b1;
            raddr_a = parent;
        end
        if (cmd.ex_start)
        begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
            raddr_b = last_idx[AW-1:0];
        end
        if (cmd.dn_read)
        begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
            raddr_a = lc[AW-1:0];
            raddr_b = rc[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[raddr_a];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[raddr_b];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_res_next   = m_res_reg;
        m_count_next = m_count_reg;
        if (cmd.ins_start)
        begin
            count_next = count_reg + CW'(1);
            pos_next   = count_reg[AW-1:0];
            cur_next   = in_key;
            val_next   = '0;
            res_next   = mhpq_pkg::RES_OK;
        end
        if (cmd.ex_start)
        begin
            res_next = mhpq_pkg::RES_OK;
        end
        if (cmd.refuse_full)
        begin
            val_next = '0;
            res_next = mhpq_pkg::RES_FULL;
        end
        if (cmd.refuse_empty)
        begin
            val_next = '0;
            res_next = mhpq_pkg::RES_EMPTY;
        end
        if (cmd.ex_load)
        begin
            val_next   = rd_a_reg;
            cur_next   = rd_b_reg;
            count_next = last_idx;
            pos_next   = '0;
        end
        if (cmd.up_step)
        begin
            pos_next = parent;
        end
        if (cmd.dn_step)
        begin
            pos_next = (dn_sel == mhpq_pkg::SEL_RIGHT) ? rc[AW-1:0] : lc[AW-1:0];
        end
        if (m_valid_reg && out_ready)
        begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_value_next = val_reg;
            m_res_next   = res_reg;
            m_count_next = count_wide[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
        m_res_reg   <= m_res_next;
        m_count_reg <= m_count_next;
    end

    assign out_valid = m_valid_reg;
    assign out_value = m_value_reg;
    assign out_res   = m_res_reg;
    assign out_count = m_count_reg;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_res_reg == mhpq_pkg::RES_EMPTY) |->
            (m_value_reg == '0 && m_count_reg == '0))
        else $error("refused extract reports a value or a nonzero count");

    a_right_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.dn_step && dn_sel == mhpq_pkg::SEL_RIGHT) |-> has_right)
        else $error("sift-down chose a right child outside the heap");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.up_step |-> (pos_reg != '0))
        else $error("sift-up stepped above the root");

endmodule

[sv/max_heap_priority_queue.sv]
// Top level of the max-heap priority queue: stream ports, controller and datapath.
//
// Binary max-heap of up to CAPACITY signed 32-bit keys. Each input transaction is
// an insert (tuser = 0) or an extract-maximum (tuser = 1) and gives exactly one
// output transaction with the extracted value (zero unless an extract succeeds),
// the key count after the operation (modulo 256) and a status: 0 ok, 1 insert
// refused because the heap is full, 2 extract refused because it is empty.
// Items are handled one at a time; the next input is taken as soon as the
// previous result sits in the output register, even if it has not yet been read.
// Timing is set by the single heap store with one write and two registered read
// ports: each sift level is a read step, then a compare-and-move step. An insert
// climbs until it reaches the root or a compare stops it; an extract loads the
// root and the last key, then moves that key down until it ends at a leaf or a
// compare stops it, and skips the sift when it removes the only key. Refused items
// go straight to the result. A result still waiting in the output register holds
// the block in its done state. The store needs no clearing after reset: only
// entries below the count are ever used.
module max_heap_priority_queue
#(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] key
    input  logic [0:0]  s_axis_tuser,   // [0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value, [39:32] count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    mhpq_pkg::cmd_t                     cmd;
    mhpq_pkg::stat_t                    stat;
    mhpq_pkg::func_t                    in_func;
    logic signed [mhpq_pkg::KEY_W-1:0]  in_key;
    logic signed [mhpq_pkg::KEY_W-1:0]  out_value;
    mhpq_pkg::res_t                     out_res;
    logic [mhpq_pkg::COUNT_W-1:0]       out_count;

    // Unpack the input transaction.
    assign in_func = mhpq_pkg::func_t'(s_axis_tuser[0]);
    assign in_key  = s_axis_tdata;

    mhpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (in_func),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_key    (in_key),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_res   (out_res),
        .out_count (out_count)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {out_count, out_value};
    assign m_axis_tuser = out_res;

endmodule
